/* hdl/cdn_pkg.sv */
package cdn_pkg;

  // Last year that the engine accepts or produces.
  localparam int MAX_YEAR = 9999;

  // Serial number of 31 December of the last year.
  localparam int LAST_DAY_INT = MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100
                                + MAX_YEAR / 400;
  localparam logic [21:0] LAST_DAY = 22'(LAST_DAY_INT);

  // Floor division by 25 of a 12-bit value: multiply by 20972, shift by 19.
  localparam int RECIP_25 = 20972;
  localparam int RECIP_SHIFT = 19;
  localparam int QUADS_PER_CENTURY = 25;

  // Restoring decomposition over 400, 100, 4 and 1 year spans.
  localparam int DIV_STEPS = 14;
  localparam logic [3:0] LAST_STEP = 4'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    OP_NEXT     = 2'd0,
    OP_TO_NUM   = 2'd1,
    OP_FROM_NUM = 2'd2,
    OP_DOY      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RES_BAD,
    RES_NEXT,
    RES_COUNT,
    RES_DOY,
    RES_DATE
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAP_WAIT,
    S_DECIDE,
    S_NEXT_WAIT,
    S_NEXT_DONE,
    S_DIV,
    S_FIN,
    S_YR_LOAD,
    S_YR_WAIT,
    S_MONTHS
  } state_t;

  typedef struct packed {
    logic      load;
    logic      next_year;
    logic      div_init;
    logic      div_step;
    logic      yr_load;
    logic      mon_step;
    logic      wr;
    res_kind_t res;
  } cdn_cmd_t;

  typedef struct packed {
    op_t  op;
    logic dn_bad;
    logic date_bad;
    logic year_roll;
    logic at_max;
    logic div_last;
    logic month_done;
  } cdn_stat_t;

  // Length of a month; zero for a month number that does not exist.
  function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
    logic [4:0] len;
    len = 5'd0;
    unique case (mo) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the months before the given one, in a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] mo);
    logic [8:0] acc;
    acc = 9'd0;
    unique case (mo)
      4'd2:    acc = 9'd31;
      4'd3:    acc = 9'd59;
      4'd4:    acc = 9'd90;
      4'd5:    acc = 9'd120;
      4'd6:    acc = 9'd151;
      4'd7:    acc = 9'd181;
      4'd8:    acc = 9'd212;
      4'd9:    acc = 9'd243;
      4'd10:   acc = 9'd273;
      4'd11:   acc = 9'd304;
      4'd12:   acc = 9'd334;
      default: acc = 9'd0;
    endcase
    return acc;
  endfunction

  // Year weight of each decomposition step: 400, 100, 4 and 1 years, each
  // shifted for a binary quotient digit.
  function automatic logic [21:0] step_years(input logic [3:0] step);
    logic [21:0] w;
    w = 22'd0;
    unique case (step)
      4'd0:    w = 22'd6400;
      4'd1:    w = 22'd3200;
      4'd2:    w = 22'd1600;
      4'd3:    w = 22'd800;
      4'd4:    w = 22'd400;
      4'd5:    w = 22'd200;
      4'd6:    w = 22'd100;
      4'd7:    w = 22'd64;
      4'd8:    w = 22'd32;
      4'd9:    w = 22'd16;
      4'd10:   w = 22'd8;
      4'd11:   w = 22'd4;
      4'd12:   w = 22'd2;
      4'd13:   w = 22'd1;
      default: w = 22'd0;
    endcase
    return w;
  endfunction

  // Day count that matches each year weight above.
  function automatic logic [21:0] step_days(input logic [3:0] step);
    logic [21:0] w;
    w = 22'd0;
    unique case (step)
      4'd0:    w = 22'd2337552;
      4'd1:    w = 22'd1168776;
      4'd2:    w = 22'd584388;
      4'd3:    w = 22'd292194;
      4'd4:    w = 22'd146097;
      4'd5:    w = 22'd73048;
      4'd6:    w = 22'd36524;
      4'd7:    w = 22'd23376;
      4'd8:    w = 22'd11688;
      4'd9:    w = 22'd5844;
      4'd10:   w = 22'd2922;
      4'd11:   w = 22'd1461;
      4'd12:   w = 22'd730;
      4'd13:   w = 22'd365;
      default: w = 22'd0;
    endcase
    return w;
  endfunction

endpackage

/* hdl/cdn_datapath.sv */
module cdn_datapath
  import cdn_pkg::*;
(
  input  logic        clk,
  input  cdn_cmd_t    cmd,
  input  logic [1:0]  opcode,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [21:0] day_number,
  output cdn_stat_t   stat,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [21:0] out_count,
  output logic        leap_year,
  output logic        invalid
);

  op_t         op_q;
  logic [4:0]  d_q;
  logic [3:0]  m_q;
  logic [13:0] y_q;
  logic [21:0] dn_q;
  logic [13:0] lyear;
  logic [7:0]  lq25;
  logic [21:0] rem;
  logic [21:0] acc;
  logic [3:0]  step;
  logic [3:0]  mo;

  logic [26:0] prod;
  logic [11:0] back;
  logic        leap;
  logic [4:0]  dim_cur;
  logic        roll;
  logic [8:0]  doy;
  logic [21:0] sub;
  logic [21:0] add;
  logic        take;
  logic [4:0]  dim_mo;

  // Leap unit: the quotient by 100 is registered, the check follows it.
  assign prod = 27'(lyear[13:2]) * 27'(RECIP_25);
  assign back = 12'(lq25) * 12'(QUADS_PER_CENTURY);
  assign leap = (lyear[1:0] == 2'b00) && ((back != lyear[13:2]) || (lq25[1:0] == 2'b00));

  // Month end and day of year of the input date.
  assign dim_cur = month_days(m_q, leap);
  assign roll    = (d_q == dim_cur);
  assign doy     = 9'(d_q) + days_before_month(m_q) + 9'(leap && (m_q > 4'd2));

  // One restoring step: days are split into years, or years into days.
  assign sub  = (op_q == OP_FROM_NUM) ? step_days(step) : step_years(step);
  assign add  = (op_q == OP_FROM_NUM) ? step_years(step) : step_days(step);
  assign take = (rem >= sub);

  // Month walk over the day of year.
  assign dim_mo = month_days(mo, leap);

  // Status towards the controller.
  always_comb begin
    stat.op         = op_q;
    stat.dn_bad     = (dn_q == 22'd0) || (dn_q > LAST_DAY);
    stat.date_bad   = (y_q == 14'd0) || (y_q > 14'(MAX_YEAR)) || (m_q == 4'd0)
                      || (m_q > 4'd12) || (d_q == 5'd0) || (d_q > dim_cur);
    stat.year_roll  = roll && (m_q == 4'd12);
    stat.at_max     = (y_q == 14'(MAX_YEAR));
    stat.div_last   = (step == LAST_STEP);
    stat.month_done = (mo == 4'd12) || (rem < 22'(dim_mo));
  end

  // Request capture and the year that the leap unit looks at.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op_t'(opcode);
      d_q   <= day;
      m_q   <= month;
      y_q   <= year;
      dn_q  <= day_number;
      lyear <= year;
    end else if (cmd.next_year) begin
      lyear <= y_q + 14'd1;
    end else if (cmd.yr_load) begin
      lyear <= acc[13:0] + 14'd1;
    end
    lq25 <= prod[26:19];
  end

  // Remainder, accumulator and step counter.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= (op_q == OP_FROM_NUM) ? (dn_q - 22'd1) : (22'(y_q) - 22'd1);
      acc  <= 22'd0;
      step <= 4'd0;
    end else if (cmd.div_step) begin
      if (take) begin
        rem <= rem - sub;
        acc <= acc + add;
      end
      step <= step + 4'd1;
    end else if (cmd.mon_step) begin
      rem <= rem - 22'(dim_mo);
    end
  end

  // Month counter.
  always_ff @(posedge clk) begin
    if (cmd.yr_load) begin
      mo <= 4'd1;
    end else if (cmd.mon_step) begin
      mo <= mo + 4'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      unique case (cmd.res)
        RES_NEXT: begin
          out_day   <= roll ? 5'd1 : (d_q + 5'd1);
          out_month <= roll ? ((m_q == 4'd12) ? 4'd1 : (m_q + 4'd1)) : m_q;
          out_year  <= (roll && (m_q == 4'd12)) ? (y_q + 14'd1) : y_q;
          out_count <= 22'd0;
          leap_year <= leap;
          invalid   <= 1'b0;
        end
        RES_COUNT: begin
          out_day   <= d_q;
          out_month <= m_q;
          out_year  <= y_q;
          out_count <= acc + 22'(doy);
          leap_year <= leap;
          invalid   <= 1'b0;
        end
        RES_DOY: begin
          out_day   <= d_q;
          out_month <= m_q;
          out_year  <= y_q;
          out_count <= 22'(doy);
          leap_year <= leap;
          invalid   <= 1'b0;
        end
        RES_DATE: begin
          out_day   <= rem[4:0] + 5'd1;
          out_month <= mo;
          out_year  <= lyear;
          out_count <= 22'd0;
          leap_year <= leap;
          invalid   <= 1'b0;
        end
        default: begin
          out_day   <= 5'd0;
          out_month <= 4'd0;
          out_year  <= 14'd0;
          out_count <= 22'd0;
          leap_year <= 1'b0;
          invalid   <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* hdl/cdn_ctrl.sv */
module cdn_ctrl
  import cdn_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cdn_stat_t stat,
  output cdn_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  state_t state;
  state_t state_next;

  // State register and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.wr;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_LEAP_WAIT;
      S_LEAP_WAIT: state_next = S_DECIDE;
      S_DECIDE: begin
        unique case (stat.op)
          OP_FROM_NUM: state_next = stat.dn_bad ? S_IDLE : S_DIV;
          OP_TO_NUM:   state_next = stat.date_bad ? S_IDLE : S_DIV;
          OP_DOY:      state_next = S_IDLE;
          OP_NEXT: begin
            if (!stat.date_bad && stat.year_roll && !stat.at_max) begin
              state_next = S_NEXT_WAIT;
            end else begin
              state_next = S_IDLE;
            end
          end
          default:     state_next = S_IDLE;
        endcase
      end
      S_NEXT_WAIT: state_next = S_NEXT_DONE;
      S_NEXT_DONE: state_next = S_IDLE;
      S_DIV: begin
        if (stat.div_last) begin
          state_next = (stat.op == OP_FROM_NUM) ? S_YR_LOAD : S_FIN;
        end
      end
      S_FIN:       state_next = S_IDLE;
      S_YR_LOAD:   state_next = S_YR_WAIT;
      S_YR_WAIT:   state_next = S_MONTHS;
      S_MONTHS:    if (stat.month_done) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    cmd.res = RES_BAD;
    unique case (state)
      S_IDLE:      cmd.load = start;
      S_LEAP_WAIT: ;
      S_DECIDE: begin
        unique case (stat.op)
          OP_FROM_NUM: begin
            if (stat.dn_bad) begin
              cmd.wr = 1'b1;
            end else begin
              cmd.div_init = 1'b1;
            end
          end
          OP_TO_NUM: begin
            if (stat.date_bad) begin
              cmd.wr = 1'b1;
            end else begin
              cmd.div_init = 1'b1;
            end
          end
          OP_DOY: begin
            cmd.wr  = 1'b1;
            cmd.res = stat.date_bad ? RES_BAD : RES_DOY;
          end
          OP_NEXT: begin
            if (stat.date_bad || (stat.year_roll && stat.at_max)) begin
              cmd.wr = 1'b1;
            end else if (stat.year_roll) begin
              cmd.next_year = 1'b1;
            end else begin
              cmd.wr  = 1'b1;
              cmd.res = RES_NEXT;
            end
          end
          default:     cmd.wr = 1'b1;
        endcase
      end
      S_NEXT_WAIT: ;
      S_NEXT_DONE: begin
        cmd.wr  = 1'b1;
        cmd.res = RES_NEXT;
      end
      S_DIV:       cmd.div_step = 1'b1;
      S_FIN: begin
        cmd.wr  = 1'b1;
        cmd.res = RES_COUNT;
      end
      S_YR_LOAD:   cmd.yr_load = 1'b1;
      S_YR_WAIT:   ;
      S_MONTHS: begin
        if (stat.month_done) begin
          cmd.wr  = 1'b1;
          cmd.res = RES_DATE;
        end else begin
          cmd.mon_step = 1'b1;
        end
      end
      default:     ;
    endcase
  end

`ifndef SYNTHESIS
  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A result is only shown once the controller is back at rest.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is still in progress");

  // Every request stays busy through S_LEAP_WAIT and S_DECIDE, while the leap unit settles.
  a_busy_min: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 busy)
    else $error("request finished before the leap unit settled");
`endif

endmodule

/* hdl/calendar_day_number_convert.sv */
// Gregorian calendar engine, proleptic, years 1 to 9999.
// A request beat is taken at a rising edge where start is high and busy is
// low; opcode, day, month, year and day_number are sampled then. Opcode 0
// gives the next date, 1 the serial day number (1 January of year 1 is day 1),
// 2 turns a day number back into a date, 3 gives the day of the year.
// The result beat stands on the out_* ports, leap_year and invalid for the one
// cycle in which done is high; the receiver cannot stall it, and busy is
// already low in that cycle, so the next request may be given at once.
// After the start beat the controller passes S_LEAP_WAIT and S_DECIDE.
// Opcode 3 and any refused request write their result in S_DECIDE, as does
// opcode 0 unless the year rolls over, when it goes on through S_NEXT_WAIT
// and S_NEXT_DONE. Opcode 1 runs the 14-step restoring decomposition over
// 400, 100, 4 and 1 year spans and writes in S_FIN; opcode 2 runs it too,
// then loads the year, waits for the leap unit, whose divide-by-100 product
// is registered, and walks the months in up to 11 steps.
// Bad dates, day numbers outside the range, and the day after the last date
// give invalid with every other field zero.
// Synchronous reset returns the controller to idle and clears done; the
// datapath registers keep their contents.
module calendar_day_number_convert
  import cdn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [4:0]  day,
  input  logic [3:0]  month,
  input  logic [13:0] year,
  input  logic [21:0] day_number,
  output logic        done,
  output logic [4:0]  out_day,
  output logic [3:0]  out_month,
  output logic [13:0] out_year,
  output logic [21:0] out_count,
  output logic        leap_year,
  output logic        invalid
);

  cdn_cmd_t  cmd;
  cdn_stat_t stat;

  // Sequencer.
  cdn_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Arithmetic and result register.
  cdn_datapath u_datapath (
    .clk        (clk),
    .cmd        (cmd),
    .opcode     (opcode),
    .day        (day),
    .month      (month),
    .year       (year),
    .day_number (day_number),
    .stat       (stat),
    .out_day    (out_day),
    .out_month  (out_month),
    .out_year   (out_year),
    .out_count  (out_count),
    .leap_year  (leap_year),
    .invalid    (invalid)
  );

endmodule
